// ----- rtl/hcs_pkg.sv -----
// Shared types for the Hamiltonian cycle search block.
// Holds the request and result payload structs and the sequencer states.
// No dependencies.
package hcs_pkg;

    localparam int ROW_WIDTH = 8;
    localparam int ROW_INDEX_WIDTH = 3;
    localparam int VERTEX_OUT_WIDTH = 3;

    typedef struct packed {
        logic [ROW_INDEX_WIDTH-1:0] row_index;
        logic [ROW_WIDTH-1:0]       row_bits;
        logic                       last_row;
    } t_req;

    typedef struct packed {
        logic                        found;
        logic [VERTEX_OUT_WIDTH-1:0] vertex;
        logic                        last;
    } t_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EMIT
    } t_state;

endpackage

// ----- rtl/hcs_adj.sv -----
// Adjacency matrix storage and edge lookup for the Hamiltonian cycle search.
// Depends on hcs_pkg for the row widths.
module hcs_adj
    import hcs_pkg::*;
#(
    parameter int NUM_VERTICES = 8
) (
    input  logic                               i_clk,
    input  logic                               i_wr_en,
    input  logic [ROW_INDEX_WIDTH-1:0]         i_wr_row,
    input  logic [ROW_WIDTH-1:0]               i_wr_bits,
    input  logic [$clog2(NUM_VERTICES)-1:0]    i_from,
    input  logic [$clog2(NUM_VERTICES+1)-1:0]  i_to,
    output logic                               o_edge
);

    localparam int VW = $clog2(NUM_VERTICES);
    localparam int CW = $clog2(NUM_VERTICES + 1);
    localparam int ROWS = (NUM_VERTICES < ROW_WIDTH) ? NUM_VERTICES : ROW_WIDTH;
    localparam int RW = $clog2(ROWS);

    logic [ROW_WIDTH-1:0] r_rows [ROWS];
    logic [ROW_INDEX_WIDTH:0] wr_ext;
    logic [VW+ROW_INDEX_WIDTH:0] from_ext;
    logic [CW+ROW_INDEX_WIDTH-1:0] to_ext;
    logic [ROW_WIDTH-1:0] row_rd;

    assign wr_ext = {1'b0, i_wr_row};
    assign from_ext = {{(ROW_INDEX_WIDTH+1){1'b0}}, i_from};
    assign to_ext = {{ROW_INDEX_WIDTH{1'b0}}, i_to};

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (wr_ext < (ROW_INDEX_WIDTH+1)'(ROWS))) begin
            r_rows[wr_ext[RW-1:0]] <= i_wr_bits;
        end
    end

    always_comb begin
        row_rd = r_rows[from_ext[RW-1:0]];
        o_edge = (from_ext < (VW+ROW_INDEX_WIDTH+1)'(ROWS))
              && (to_ext < (CW+ROW_INDEX_WIDTH)'(ROW_WIDTH))
              && row_rd[to_ext[ROW_INDEX_WIDTH-1:0]];
    end

endmodule

// ----- rtl/hamiltonian_cycle_search.sv -----
// Top level of the Hamiltonian cycle search block.
// Depends on hcs_pkg and hcs_adj.
//
// Usage: a request is taken at a rising edge with start high and busy low.
// Each request stores one adjacency row (rows at or above NUM_VERTICES are
// dropped). A request with last_row set stores its row and then starts a
// depth-first search from vertex 0; busy stays high through the search and
// drops in the cycle that carries its final result. Row loads are taken back
// to back. The search tests one candidate vertex per cycle in a single edge
// and visited check, so its length depends on the graph and grows with each
// candidate tried, backtrack and closing-edge check. A found cycle leaves as
// NUM_VERTICES + 1 back-to-back results (the path from vertex 0 and then
// vertex 0 again, the final one with last set); otherwise a single result
// with found clear and last set is sent. Each result is on o_res for exactly
// one cycle with o_strobe high; the receiver cannot stall it. A synchronous
// reset returns the sequencer to idle and resets the depth, candidates,
// visited set and strobe; path, result and adjacency rows keep what they held.
module hamiltonian_cycle_search
    import hcs_pkg::*;
#(
    parameter int NUM_VERTICES = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_strobe,
    output t_res o_res
);

    localparam int VW = $clog2(NUM_VERTICES);
    localparam int CW = $clog2(NUM_VERTICES + 1);
    localparam logic [CW-1:0] NV = CW'(NUM_VERTICES);
    localparam logic [CW-1:0] ONE = CW'(1);

    t_state r_state, n_state;
    logic [CW-1:0] r_depth, n_depth;
    logic [CW-1:0] r_cand [NUM_VERTICES];
    logic [CW-1:0] n_cand [NUM_VERTICES];
    logic [VW-1:0] r_path [NUM_VERTICES];
    logic [VW-1:0] n_path [NUM_VERTICES];
    logic [NUM_VERTICES-1:0] r_visited, n_visited;
    logic [CW-1:0] r_emit, n_emit;
    logic r_strobe, n_strobe;
    t_res r_res, n_res;

    logic accept;
    logic [VW-1:0] path_addr;
    logic [VW-1:0] path_rd;
    logic [CW-1:0] cand_rd;
    logic [CW-1:0] test_to;
    logic edge_ok;
    logic [VW+VERTEX_OUT_WIDTH-1:0] path_ext;
    logic [CW-1:0] depth_m1;

    assign accept = start && !busy;
    assign busy = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res = r_res;

    assign depth_m1 = r_depth - ONE;
    assign path_addr = (r_state == S_EMIT) ? r_emit[VW-1:0] : depth_m1[VW-1:0];
    assign path_rd = r_path[path_addr];
    assign cand_rd = r_cand[r_depth[VW-1:0]];
    assign test_to = (r_depth < NV) ? cand_rd : '0;
    assign path_ext = {{VERTEX_OUT_WIDTH{1'b0}}, path_rd};

    hcs_adj #(
        .NUM_VERTICES(NUM_VERTICES)
    ) u_adj (
        .i_clk    (i_clk),
        .i_wr_en  (accept),
        .i_wr_row (i_req.row_index),
        .i_wr_bits(i_req.row_bits),
        .i_from   (path_rd),
        .i_to     (test_to),
        .o_edge   (edge_ok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= ONE;
            r_visited <= NUM_VERTICES'(1);
            r_emit <= '0;
            r_strobe <= 1'b0;
            for (int i = 0; i < NUM_VERTICES; i++) begin
                r_cand[i] <= ONE;
            end
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_visited <= n_visited;
            r_emit <= n_emit;
            r_strobe <= n_strobe;
            r_cand <= n_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        r_path <= n_path;
        r_res <= n_res;
    end

    always_comb begin
        n_state = r_state;
        n_depth = r_depth;
        n_cand = r_cand;
        n_path = r_path;
        n_visited = r_visited;
        n_emit = r_emit;
        n_strobe = 1'b0;
        n_res = r_res;

        case (r_state)
            S_IDLE: begin
                if (accept && i_req.last_row) begin
                    n_state = S_SEARCH;
                    n_depth = ONE;
                    n_visited = NUM_VERTICES'(1);
                    n_emit = '0;
                    n_path[0] = '0;
                    for (int i = 0; i < NUM_VERTICES; i++) begin
                        n_cand[i] = ONE;
                    end
                end
            end
            S_SEARCH: begin
                if (r_depth >= NV) begin
                    if (edge_ok) begin
                        n_state = S_EMIT;
                        n_emit = '0;
                    end else begin
                        n_depth = NV - ONE;
                        n_visited[path_rd] = 1'b0;
                    end
                end else if (cand_rd < NV) begin
                    n_cand[r_depth[VW-1:0]] = cand_rd + ONE;
                    if (edge_ok && !r_visited[cand_rd[VW-1:0]]) begin
                        n_path[r_depth[VW-1:0]] = cand_rd[VW-1:0];
                        n_visited[cand_rd[VW-1:0]] = 1'b1;
                        n_depth = r_depth + ONE;
                        if ((r_depth + ONE) < NV) begin
                            n_cand[r_depth[VW-1:0] + VW'(1)] = ONE;
                        end
                    end
                end else begin
                    n_cand[r_depth[VW-1:0]] = ONE;
                    if (r_depth <= ONE) begin
                        n_state = S_IDLE;
                        n_strobe = 1'b1;
                        n_res.found = 1'b0;
                        n_res.vertex = '0;
                        n_res.last = 1'b1;
                    end else begin
                        n_depth = depth_m1;
                        n_visited[path_rd] = 1'b0;
                    end
                end
            end
            S_EMIT: begin
                n_strobe = 1'b1;
                n_res.found = 1'b1;
                if (r_emit >= NV) begin
                    n_res.vertex = '0;
                    n_res.last = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_res.vertex = (r_emit == '0) ? '0 : path_ext[VERTEX_OUT_WIDTH-1:0];
                    n_res.last = 1'b0;
                    n_emit = r_emit + ONE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- test/hamiltonian_cycle_search_checker.sv -----
`timescale 1ns / 1ps
// Checker for hamiltonian_cycle_search: keeps its own copy of the adjacency rows,
// predicts each search and compares every result strobe with the oldest prediction.
// Depends on hcs_pkg.
module hamiltonian_cycle_search_checker
    import hcs_pkg::*;
#(
    parameter int NUM_VERTICES = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_req i_req,
    input  logic i_strobe,
    input  t_res i_res,
    output int   o_pending,
    output int   o_fail_count
);

    typedef logic [NUM_VERTICES-1:0][ROW_WIDTH-1:0] t_matrix;
    typedef logic [NUM_VERTICES-1:0][7:0] t_tour;

    t_matrix adj_rows;
    t_res    expected_results[$];
    int      pending_count = 0;
    int      fails = 0;

    assign o_pending = pending_count;
    assign o_fail_count = fails;

    task automatic report(string what, int expected_val, int got_val);
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what,
                 expected_val, got_val);
        fails++;
    endtask

    function automatic bit find_cycle(input t_matrix adj, output t_tour tour);
        int                    next_try [NUM_VERTICES];
        logic [NUM_VERTICES-1:0] on_path;
        int                    depth;
        int                    v;
        bit                    done;
        bit                    hit;
        tour = '0;
        on_path = 1;
        depth = 1;
        done = 1'b0;
        hit = 1'b0;
        foreach (next_try[i]) next_try[i] = 1;
        while (!done) begin
            if (depth == NUM_VERTICES) begin
                if (adj[tour[NUM_VERTICES-1]][0]) begin
                    hit = 1'b1;
                    done = 1'b1;
                end else begin
                    depth = NUM_VERTICES - 1;
                    on_path[tour[depth]] = 1'b0;
                end
            end else begin
                v = next_try[depth];
                while (v < NUM_VERTICES &&
                       (v >= ROW_WIDTH || !adj[tour[depth-1]][v] || on_path[v])) begin
                    v++;
                end
                if (v < NUM_VERTICES) begin
                    next_try[depth] = v + 1;
                    tour[depth] = 8'(v);
                    on_path[v] = 1'b1;
                    depth++;
                    if (depth < NUM_VERTICES) next_try[depth] = 1;
                end else begin
                    next_try[depth] = 1;
                    if (depth <= 1) begin
                        done = 1'b1;
                    end else begin
                        depth--;
                        on_path[tour[depth]] = 1'b0;
                    end
                end
            end
        end
        return hit;
    endfunction

    always @(posedge i_clk) begin
        t_res  exp_res;
        t_tour tour;
        if (i_rst_n) begin
            if (i_strobe) begin
                if (expected_results.size() == 0) begin
                    report("unexpected result", 0, int'(i_res));
                end else begin
                    exp_res = expected_results.pop_front();
                    if (i_res.found !== exp_res.found)
                        report("found", exp_res.found, i_res.found);
                    if (i_res.vertex !== exp_res.vertex)
                        report("vertex", exp_res.vertex, i_res.vertex);
                    if (i_res.last !== exp_res.last)
                        report("last", exp_res.last, i_res.last);
                end
            end
            if (i_start && !i_busy) begin
                if (int'(i_req.row_index) < NUM_VERTICES)
                    adj_rows[i_req.row_index] = i_req.row_bits;
                if (i_req.last_row) begin
                    if (find_cycle(adj_rows, tour)) begin
                        for (int k = 0; k < NUM_VERTICES; k++) begin
                            expected_results.push_back(t_res'{
                                found: 1'b1,
                                vertex: tour[k][VERTEX_OUT_WIDTH-1:0],
                                last: 1'b0});
                        end
                        expected_results.push_back(t_res'{found: 1'b1, vertex: '0,
                                                          last: 1'b1});
                    end else begin
                        expected_results.push_back(t_res'{found: 1'b0, vertex: '0,
                                                          last: 1'b1});
                    end
                end
            end
        end
        pending_count <= expected_results.size();
    end

endmodule

// ----- test/hamiltonian_cycle_search_test.sv -----
`timescale 1ns / 1ps
// Testbench top for hamiltonian_cycle_search: drives row-load and search requests,
// first a directed set of graphs and then random ones. Depends on hcs_pkg, the
// block and hamiltonian_cycle_search_checker, which does all result checking.
module hamiltonian_cycle_search_test;
    import hcs_pkg::*;

    localparam int NUM_VERTICES = 8;
    localparam int STALL_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 250;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    t_req req = '0;
    logic busy;
    logic strobe;
    t_res res;
    int   pending;
    int   fail_count;
    int   idle_cycles = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    hamiltonian_cycle_search #(
        .NUM_VERTICES(NUM_VERTICES)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .start   (start),
        .i_req   (req),
        .busy    (busy),
        .o_strobe(strobe),
        .o_res   (res)
    );

    hamiltonian_cycle_search_checker #(
        .NUM_VERTICES(NUM_VERTICES)
    ) checker_inst (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_req       (req),
        .i_strobe    (strobe),
        .i_res       (res),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    always @(posedge clk) begin
        if ((start && !busy) || strobe) begin
            idle_cycles <= 0;
        end else begin
            if (idle_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_row(int row, logic [ROW_WIDTH-1:0] bits, bit last, int gap);
        repeat (gap) begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        req <= t_req'{row_index: ROW_INDEX_WIDTH'(row), row_bits: bits, last_row: last};
        do @(posedge clk); while (busy);
    endtask

    function automatic logic [ROW_WIDTH-1:0] draw_row(int density);
        case (density)
            0: return ROW_WIDTH'($urandom & $urandom);
            1: return ROW_WIDTH'($urandom);
            2: return ROW_WIDTH'($urandom | $urandom);
            default: return ROW_WIDTH'($urandom | $urandom | $urandom);
        endcase
    endfunction

    initial begin
        int sent;
        int row_count;
        int density;
        int gap_max;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Every row is written before the first search so no stale row is read.
        for (int r = 0; r < NUM_VERTICES; r++) send_row(r, 8'hFF, r == NUM_VERTICES - 1, 0);
        send_row(0, 8'h00, 1'b1, 2);
        send_row(0, 8'hFE, 1'b1, 0);
        // No edge returns to vertex 0, so the whole search tree is walked.
        for (int r = 0; r < NUM_VERTICES; r++)
            send_row(r, 8'hFE, r == NUM_VERTICES - 1, r % 3);
        send_row(1, 8'hFF, 1'b1, 1);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            row_count = $urandom_range(1, NUM_VERTICES);
            density = $urandom_range(0, 3);
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
            for (int k = 0; k < row_count; k++) begin
                send_row($urandom_range(0, NUM_VERTICES - 1), draw_row(density),
                         k == row_count - 1, $urandom_range(0, gap_max));
                sent++;
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
